// ===== rtl/ncpp_pkg.sv =====
package ncpp_pkg;

  localparam int unsigned DefMaxPoints  = 256;
  localparam int unsigned DefMaxParcels = 8;
  localparam int unsigned CoordW = 24;
  localparam int unsigned ProbW  = 17;
  localparam int unsigned ValueW = 42;
  localparam int unsigned DistW  = 51;
  localparam logic [ProbW-1:0] Q16One = 17'd65536;
  localparam logic [ValueW-1:0] AreaMax = {ValueW{1'b1}};
  localparam logic [9:0] Permille = 10'd1000;

  typedef enum logic [1:0] {
    OpLoadPoint = 2'd0,
    OpLoadProb  = 2'd1,
    OpQuery     = 2'd2,
    OpReadAreas = 2'd3
  } op_e;

  // One classified command passed from the front end to the back end.
  typedef struct packed {
    op_e               op;
    logic              slot_ok;
    logic [7:0]        pidx;
    logic [2:0]        parc;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [ProbW-1:0]  prob;
  } cmd_t;

endpackage

// ===== rtl/nearest_contour_point_probability.sv =====
// A query scans the points in use, then shows one result per parcel in use, each
// through the StPAdr, StPMul and StEmit states; a read shows its area sums from
// StEmit, one per cycle.
// The point scan reads one stored point per cycle; the back end takes no new command until it is done with the last.
// Loads pass through the two-entry queue; reset clears the area sums and sets
// points_in_use 256, parcels_in_use 4. The receiver cannot stall (done_o).
module nearest_contour_point_probability import ncpp_pkg::*; #(
  parameter int unsigned MaxPoints  = DefMaxPoints,
  parameter int unsigned MaxParcels = DefMaxParcels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        point_index_i,
  input  logic [2:0]        parcel_index_i,
  input  logic [CoordW-1:0] coord_x_i,
  input  logic [CoordW-1:0] coord_y_i,
  input  logic [CoordW-1:0] coord_z_i,
  input  logic [ProbW-1:0]  probability_i,
  output logic              done_o,
  output logic              kind_o,
  output logic [7:0]        closest_point_o,
  output logic [2:0]        parcel_o,
  output logic [ValueW-1:0] value_o,
  output logic              last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [2:0] AddrPoints  = 3'd0;
  localparam logic [2:0] AddrParcels = 3'd4;

  logic [8:0] points_q;
  logic [3:0] parcels_q;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Register port.
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      AddrPoints:  prdata = 32'(points_q);
      AddrParcels: prdata = 32'(parcels_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q  <= 9'd256;
      parcels_q <= 4'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrPoints) points_q <= pwdata[8:0];
      if (paddr == AddrParcels) parcels_q <= pwdata[3:0];
    end
  end

  ncpp_front #(.MaxPoints(MaxPoints), .MaxParcels(MaxParcels)) u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .operation_i, .point_index_i, .parcel_index_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .probability_i,
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  ncpp_back #(.MaxPoints(MaxPoints), .MaxParcels(MaxParcels)) u_back (
    .clk_i, .rst_ni, .points_in_use_i(points_q), .parcels_in_use_i(parcels_q),
    .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .done_o, .kind_o, .closest_point_o, .parcel_o, .value_o, .last_o
  );

endmodule

// ===== rtl/ncpp_front.sv =====
// Front end: classifies every command and queues it in order for the back end.
module ncpp_front import ncpp_pkg::*; #(
  parameter int unsigned MaxPoints  = DefMaxPoints,
  parameter int unsigned MaxParcels = DefMaxParcels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        point_index_i,
  input  logic [2:0]        parcel_index_i,
  input  logic [CoordW-1:0] coord_x_i,
  input  logic [CoordW-1:0] coord_y_i,
  input  logic [CoordW-1:0] coord_z_i,
  input  logic [ProbW-1:0]  probability_i,
  output logic              q_valid_o,
  output cmd_t              q_cmd_o,
  input  logic              q_pop_i
);

  localparam int unsigned Depth = 2;

  logic       acc;
  logic       idx_ok, par_ok;
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  cmd_t       fifo_q [Depth];
  logic       push;

  assign busy_o = (cnt_q == 2'(Depth));
  assign acc    = start_i && !busy_o;
  assign idx_ok = 32'(point_index_i) < MaxPoints;
  assign par_ok = 32'(parcel_index_i) < MaxParcels;

  // Every command enters the queue, so loads keep their order with queries.
  assign push = acc;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = fifo_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
    end
  end

  // Loads outside the tables are marked so the back end drops them.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= '{op: op_e'(operation_i),
                        slot_ok: (operation_i == OpLoadProb) ? (idx_ok && par_ok) : idx_ok,
                        pidx: point_index_i, parc: parcel_index_i,
                        x: coord_x_i, y: coord_y_i, z: coord_z_i,
                        prob: (probability_i > Q16One) ? Q16One : probability_i};
    end
  end

endmodule

// ===== rtl/ncpp_back.sv =====
// Back end: nearest point scan, one point per cycle, then per-parcel emission.
module ncpp_back import ncpp_pkg::*; #(
  parameter int unsigned MaxPoints  = DefMaxPoints,
  parameter int unsigned MaxParcels = DefMaxParcels,
  localparam int unsigned PW = $clog2(MaxPoints),
  localparam int unsigned AW = $clog2(MaxPoints) + ((MaxParcels > 1) ? $clog2(MaxParcels) : 0)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [8:0]        points_in_use_i,
  input  logic [3:0]        parcels_in_use_i,
  input  logic              q_valid_i,
  input  cmd_t              q_cmd_i,
  output logic              q_pop_o,
  output logic              done_o,
  output logic              kind_o,
  output logic [7:0]        closest_point_o,
  output logic [2:0]        parcel_o,
  output logic [ValueW-1:0] value_o,
  output logic              last_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StScan = 7'b0000010,
    StDist = 7'b0000100,
    StCmp  = 7'b0001000,
    StPAdr = 7'b0010000,
    StPMul = 7'b0100000,
    StEmit = 7'b1000000
  } state_e;

  localparam int unsigned CW = PW + 1;

  state_e st_q;
  logic [3*CoordW-1:0] pt_mem [MaxPoints];
  logic [ProbW-1:0]    pr_mem [MaxParcels*MaxPoints];
  logic [ValueW-1:0]   area_q [MaxParcels];
  cmd_t                cmd_q;
  logic                is_rd;
  logic                pt_we, pr_we;
  logic [AW-1:0]       pr_wa;
  logic [CW-1:0]       n_eff, rd_cnt_q, cmp_cnt_q;
  logic [3:0]          np_eff;
  logic [2:0]          par_q;
  logic [3*CoordW-1:0] pt_rd_q;
  logic                pt_vld_q;
  logic [24:0]         dx, dy, dz;
  logic [49:0]         sqx_q, sqy_q, sqz_q;
  logic                sq_vld_q;
  logic [DistW-1:0]    dsum, best_d_q;
  logic [PW-1:0]       best_q;
  logic [ProbW-1:0]    pr_rd_q;
  logic [26:0]         pm_q;
  logic [ValueW:0]     sum;
  logic                out_v_q;

  // Effective register values.
  always_comb begin
    if (points_in_use_i == 9'd0) n_eff = CW'(1);
    else if (32'(points_in_use_i) > MaxPoints) n_eff = CW'(MaxPoints);
    else n_eff = CW'(points_in_use_i);
    if (parcels_in_use_i == 4'd0) np_eff = 4'd1;
    else if (32'(parcels_in_use_i) > MaxParcels) np_eff = 4'(MaxParcels);
    else np_eff = parcels_in_use_i;
  end

  // Loads are carried out as they leave the queue, in order with queries.
  assign pt_we = (st_q == StIdle) && q_valid_i && (q_cmd_i.op == OpLoadPoint) &&
                 q_cmd_i.slot_ok;
  assign pr_we = (st_q == StIdle) && q_valid_i && (q_cmd_i.op == OpLoadProb) &&
                 q_cmd_i.slot_ok;
  assign pr_wa = AW'((32'(q_cmd_i.parc) * MaxPoints) + 32'(q_cmd_i.pidx));
  assign is_rd = (cmd_q.op == OpReadAreas);

  // Stores.
  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[PW'(q_cmd_i.pidx)] <= {q_cmd_i.z, q_cmd_i.y, q_cmd_i.x};
    pt_rd_q <= pt_mem[rd_cnt_q[PW-1:0]];
    if (pr_we) pr_mem[pr_wa] <= q_cmd_i.prob;
    pr_rd_q <= pr_mem[AW'((32'(par_q) * MaxPoints) + 32'(best_q))];
  end

  // Absolute differences, combinational, and their registered squares.
  function automatic logic [24:0] absdiff(input logic [CoordW-1:0] a, input logic [CoordW-1:0] b);
    logic signed [24:0] d;
    d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    absdiff = d[24] ? 25'(-d) : 25'(d);
  endfunction

  assign dx = absdiff(pt_rd_q[CoordW-1:0], cmd_q.x);
  assign dy = absdiff(pt_rd_q[2*CoordW-1:CoordW], cmd_q.y);
  assign dz = absdiff(pt_rd_q[3*CoordW-1:2*CoordW], cmd_q.z);
  assign dsum = DistW'(sqx_q) + DistW'(sqy_q) + DistW'(sqz_q);
  assign sum  = {1'b0, area_q[par_q]} + (ValueW+1)'(pm_q[26:16]);

  always_ff @(posedge clk_i) begin
    sqx_q <= dx * dx;
    sqy_q <= dy * dy;
    sqz_q <= dz * dz;
    pm_q  <= pr_rd_q * Permille;
  end

  assign q_pop_o = (st_q == StIdle) && q_valid_i;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      rd_cnt_q  <= '0;
      cmp_cnt_q <= '0;
      par_q     <= '0;
      best_q    <= '0;
      pt_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      out_v_q   <= 1'b0;
      for (int i = 0; i < MaxParcels; i++) area_q[i] <= '0;
      cmd_q <= '0;
      best_d_q <= '0;
      kind_o <= 1'b0;
      closest_point_o <= '0;
      parcel_o <= '0;
      value_o <= '0;
      last_o <= 1'b0;
    end else begin
      out_v_q <= 1'b0;
      pt_vld_q <= 1'b0;
      sq_vld_q <= pt_vld_q;
      case (st_q)
        StIdle: begin
          if (q_valid_i) begin
            cmd_q <= q_cmd_i;
            par_q <= '0;
            rd_cnt_q <= '0;
            cmp_cnt_q <= '0;
            if (q_cmd_i.op == OpReadAreas) st_q <= StEmit;
            else if (q_cmd_i.op == OpQuery) st_q <= StScan;
          end
        end
        StScan: begin
          pt_vld_q <= 1'b1;
          rd_cnt_q <= rd_cnt_q + CW'(1);
          if (rd_cnt_q + CW'(1) == n_eff) st_q <= StDist;
        end
        StDist: begin
          if (!pt_vld_q && !sq_vld_q) st_q <= StCmp;
        end
        StCmp: st_q <= StPAdr;
        StPAdr: st_q <= StPMul;
        StPMul: st_q <= StEmit;
        StEmit: begin
          out_v_q <= 1'b1;
          parcel_o <= par_q;
          last_o <= (4'(par_q) + 4'd1 == np_eff);
          kind_o <= is_rd;
          if (is_rd) begin
            closest_point_o <= '0;
            value_o <= area_q[par_q];
          end else begin
            closest_point_o <= 8'(best_q);
            value_o <= ValueW'(pm_q[26:16]);
            area_q[par_q] <= sum[ValueW] ? AreaMax : sum[ValueW-1:0];
          end
          if (4'(par_q) + 4'd1 == np_eff) begin
            if (is_rd) for (int i = 0; i < MaxParcels; i++) area_q[i] <= '0;
            st_q <= StIdle;
          end else begin
            par_q <= par_q + 3'd1;
            st_q <= is_rd ? StEmit : StPAdr;
          end
        end
        default: st_q <= StIdle;
      endcase
      // Running minimum; ties keep the lower index.
      if (sq_vld_q) begin
        cmp_cnt_q <= cmp_cnt_q + CW'(1);
        if (cmp_cnt_q == '0 || dsum < best_d_q) begin
          best_d_q <= dsum;
          best_q <= cmp_cnt_q[PW-1:0];
        end
      end
    end
  end

  assign done_o = out_v_q;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import ncpp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Size of the point table that the run fills and searches.
  localparam int FillPoints = 16;

  // One query result or area sum as it should appear on the result ports.
  typedef struct {
    logic              kind;
    logic [7:0]        closest_point;
    logic [2:0]        parcel;
    logic [ValueW-1:0] value;
    logic              last;
  } area_result_t;

  // Tracks the point table, probabilities and area sums, and keeps the results
  // that every accepted command should produce, oldest first.
  class area_scoreboard;
    logic signed [CoordW-1:0] pt_x [DefMaxPoints];
    logic signed [CoordW-1:0] pt_y [DefMaxPoints];
    logic signed [CoordW-1:0] pt_z [DefMaxPoints];
    logic [ProbW-1:0]  prob_tab [DefMaxParcels][DefMaxPoints];
    logic [ValueW-1:0] sums [DefMaxParcels];
    logic [8:0]        points_reg;
    logic [3:0]        parcels_reg;
    area_result_t      expected_q[$];
    int                failures;

    function new();
      points_reg  = 9'd256;
      parcels_reg = 4'd4;
      failures    = 0;
      foreach (sums[i]) sums[i] = '0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      if (idx == 0) points_reg = val[8:0];
      else parcels_reg = val[3:0];
    endfunction

    function int active_points();
      if (points_reg == 0) return 1;
      if (points_reg > DefMaxPoints) return DefMaxPoints;
      return points_reg;
    endfunction

    function int active_parcels();
      if (parcels_reg == 0) return 1;
      if (parcels_reg > DefMaxParcels) return DefMaxParcels;
      return parcels_reg;
    endfunction

    function longint unsigned sq_dist(int idx, logic signed [CoordW-1:0] x,
                                      logic signed [CoordW-1:0] y,
                                      logic signed [CoordW-1:0] z);
      longint dx, dy, dz;
      dx = longint'(pt_x[idx]) - longint'(x);
      dy = longint'(pt_y[idx]) - longint'(y);
      dz = longint'(pt_z[idx]) - longint'(z);
      return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Applies one accepted command and queues the results it causes.
    function void note_command(op_e op, logic [7:0] pidx, logic [2:0] parc,
                               logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                               logic [CoordW-1:0] z, logic [ProbW-1:0] prob);
      int np, n, best;
      longint unsigned best_d, d, pm, s;
      area_result_t r;
      np = active_parcels();
      case (op)
        OpLoadPoint: begin
          pt_x[pidx] = x;
          pt_y[pidx] = y;
          pt_z[pidx] = z;
        end
        OpLoadProb: begin
          prob_tab[parc][pidx] = (prob > Q16One) ? Q16One : prob;
        end
        OpQuery: begin
          n = active_points();
          best = 0;
          best_d = sq_dist(0, x, y, z);
          for (int i = 1; i < n; i++) begin
            d = sq_dist(i, x, y, z);
            if (d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          for (int i = 0; i < np; i++) begin
            pm = (longint'(prob_tab[i][best]) * 1000) / 65536;
            s = longint'(sums[i]) + pm;
            sums[i] = (s > longint'(AreaMax)) ? AreaMax : s[ValueW-1:0];
            r.kind = 1'b0;
            r.closest_point = best[7:0];
            r.parcel = i[2:0];
            r.value = pm[ValueW-1:0];
            r.last = (i + 1 == np);
            expected_q.push_back(r);
          end
        end
        default: begin
          for (int i = 0; i < np; i++) begin
            r.kind = 1'b1;
            r.closest_point = '0;
            r.parcel = i[2:0];
            r.value = sums[i];
            r.last = (i + 1 == np);
            expected_q.push_back(r);
          end
          foreach (sums[i]) sums[i] = '0;
        end
      endcase
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(area_result_t got);
      area_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d parcel %0d value %0d",
               got.kind, got.parcel, got.value);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("kind: expected %0d, actual %0d", exp_r.kind, got.kind);
        failures++;
      end
      if (got.closest_point !== exp_r.closest_point) begin
        $error("closest_point: expected %0d, actual %0d",
               exp_r.closest_point, got.closest_point);
        failures++;
      end
      if (got.parcel !== exp_r.parcel) begin
        $error("parcel: expected %0d, actual %0d", exp_r.parcel, got.parcel);
        failures++;
      end
      if (got.value !== exp_r.value) begin
        $error("value: expected %0d, actual %0d", exp_r.value, got.value);
        failures++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d, actual %0d", exp_r.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        operation_i = '0;
  logic [7:0]        point_index_i = '0;
  logic [2:0]        parcel_index_i = '0;
  logic [CoordW-1:0] coord_x_i = '0;
  logic [CoordW-1:0] coord_y_i = '0;
  logic [CoordW-1:0] coord_z_i = '0;
  logic [ProbW-1:0]  probability_i = '0;
  logic              done_o;
  logic              kind_o;
  logic [7:0]        closest_point_o;
  logic [2:0]        parcel_o;
  logic [ValueW-1:0] value_o;
  logic              last_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  area_scoreboard sb = new();
  int gap_pct = 0;

  nearest_contour_point_probability u_top (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Every strobed result is taken at the edge that ends its cycle.
  always @(posedge clk_i) begin
    area_result_t got;
    if (rst_ni && done_o) begin
      got.kind = kind_o;
      got.closest_point = closest_point_o;
      got.parcel = parcel_o;
      got.value = value_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  // Sends one command and holds it until the block accepts it.
  task automatic send_cmd(op_e op, logic [7:0] pidx, logic [2:0] parc,
                          logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                          logic [CoordW-1:0] z, logic [ProbW-1:0] prob);
    int gap;
    @(negedge clk_i);
    operation_i = op;
    point_index_i = pidx;
    parcel_index_i = parc;
    coord_x_i = x;
    coord_y_i = y;
    coord_z_i = z;
    probability_i = prob;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(op, pidx, parc, x, y, z, prob);
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      operation_i = 2'($urandom);
      gap = $urandom_range(1, 4);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Lowers start and lets every outstanding result drain.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Register write over the configuration port, only while the block is idle.
  task automatic write_reg(int idx, logic [31:0] val);
    drain();
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(idx * 4);
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [CoordW-1:0] near(logic [CoordW-1:0] c);
    return c + CoordW'($urandom_range(0, 64)) - CoordW'(32);
  endfunction

  function automatic logic [CoordW-1:0] any_coord();
    case ($urandom_range(3))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Random traffic: mostly queries near stored points, with loads and reads.
  task automatic random_cmds(int count);
    int sel, k, np;
    logic [7:0] pidx;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      pidx = 8'($urandom);
      np = sb.active_points();
      k = $urandom_range(np - 1);
      if (sel < 55) begin
        send_cmd(OpQuery, pidx, 3'($urandom), near(sb.pt_x[k]), near(sb.pt_y[k]),
                 near(sb.pt_z[k]), 17'($urandom));
      end else if (sel < 65) begin
        send_cmd(OpQuery, pidx, 3'($urandom), any_coord(), any_coord(), any_coord(),
                 17'($urandom));
      end else if (sel < 75) begin
        send_cmd(OpReadAreas, pidx, 3'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), 17'($urandom));
      end else if (sel < 88) begin
        // Copying another point's coordinates makes distance ties.
        if ($urandom_range(1))
          send_cmd(OpLoadPoint, pidx, 3'($urandom), sb.pt_x[k], sb.pt_y[k], sb.pt_z[k],
                   17'($urandom));
        else
          send_cmd(OpLoadPoint, pidx, 3'($urandom), any_coord(), any_coord(),
                   any_coord(), 17'($urandom));
      end else begin
        send_cmd(OpLoadProb, pidx, 3'($urandom), 24'($urandom), 24'($urandom),
                 24'($urandom), $urandom_range(1) ? 17'($urandom_range(65536)) :
                 17'($urandom));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int pts [8] = '{1, 0, 16, 12, 5, 16, 3, 2};
    int prc [8] = '{1, 0, 15, 8, 3, 8, 2, 5};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Search a small table, and fill it with every probability so that no
    // query reads an empty entry.
    write_reg(0, 32'(FillPoints));
    for (int p = 0; p < FillPoints; p++)
      send_cmd(OpLoadPoint, 8'(p), 3'($urandom), 24'($urandom), 24'($urandom),
               24'($urandom), 17'($urandom));
    for (int q = 0; q < DefMaxParcels; q++)
      for (int p = 0; p < FillPoints; p++)
        send_cmd(OpLoadProb, 8'(p), 3'(q), 24'($urandom), 24'($urandom),
                 24'($urandom), 17'($urandom_range(65536)));

    // Directed: extreme coordinates, clamped and boundary probabilities, ties.
    send_cmd(OpLoadPoint, 8'd0, 3'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 17'd0);
    send_cmd(OpLoadPoint, 8'd255, 3'd7, 24'h800000, 24'h800000, 24'h800000, 17'd0);
    send_cmd(OpLoadProb, 8'd0, 3'd0, 24'd0, 24'd0, 24'd0, 17'h1FFFF);
    send_cmd(OpLoadProb, 8'd0, 3'd1, 24'd0, 24'd0, 24'd0, 17'd0);
    send_cmd(OpLoadProb, 8'd0, 3'd2, 24'd0, 24'd0, 24'd0, 17'd65536);
    send_cmd(OpLoadProb, 8'd0, 3'd3, 24'd0, 24'd0, 24'd0, 17'd65535);
    send_cmd(OpLoadProb, 8'd255, 3'd7, 24'd0, 24'd0, 24'd0, 17'd65537);
    send_cmd(OpQuery, 8'd0, 3'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 17'd0);
    send_cmd(OpQuery, 8'd0, 3'd0, 24'h800000, 24'h800000, 24'h800000, 17'd0);
    send_cmd(OpQuery, 8'd0, 3'd0, 24'h800000, 24'h7FFFFF, 24'h800000, 17'd0);
    send_cmd(OpReadAreas, 8'd0, 3'd0, 24'd0, 24'd0, 24'd0, 17'd0);
    send_cmd(OpLoadPoint, 8'd1, 3'd0, 24'd100, 24'd0, 24'd0, 17'd0);
    send_cmd(OpLoadPoint, 8'd2, 3'd0, 24'hFFFF9C, 24'd0, 24'd0, 17'd0);
    send_cmd(OpLoadPoint, 8'd3, 3'd0, 24'd100, 24'd0, 24'd0, 17'd0);
    send_cmd(OpQuery, 8'd0, 3'd0, 24'd0, 24'd0, 24'd0, 17'd0);
    send_cmd(OpQuery, 8'd0, 3'd0, 24'd100, 24'd0, 24'd0, 17'd0);
    send_cmd(OpReadAreas, 8'd0, 3'd0, 24'd0, 24'd0, 24'd0, 17'd0);
    send_cmd(OpReadAreas, 8'd0, 3'd0, 24'd0, 24'd0, 24'd0, 17'd0);
    random_cmds(30);

    // Random phases over several register settings and sender idle rates.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(0, 32'(pts[ph]));
      write_reg(1, 32'(prc[ph]));
      gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 83 : 7);
      random_cmds(20);
    end

    drain();
    if (sb.failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
